// ===== hw/rtl/mtd_pkg.sv =====
// shared types and constants of the motor telemetry deframer
`default_nettype none
package mtd_pkg;

  localparam int FRAME_STORE = 18;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;

  localparam logic [7:0] SYNC_BYTE   = 8'h75;
  localparam logic [7:0] HEAD_BYTE   = 8'hAA;
  localparam logic [7:0] FOOT_BYTE   = 8'hFF;
  localparam logic [7:0] SRC_LEFT    = 8'h11;
  localparam logic [7:0] SRC_RIGHT   = 8'h12;
  localparam logic [9:0] MV_PER_VOLT = 10'd1000;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_POLL = 2'd1;
  localparam logic [1:0] KIND_SLOT = 2'd2;

  localparam logic [2:0] ST_LEFT    = 3'd0;
  localparam logic [2:0] ST_RIGHT   = 3'd1;
  localparam logic [2:0] ST_BAD     = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_PARTIAL = 3'd4;
  localparam logic [2:0] ST_TIMEOUT = 3'd5;
  localparam logic [2:0] ST_SEND    = 3'd6;

  localparam logic [2:0] REG_LEFT_TARGET  = 3'd0;
  localparam logic [2:0] REG_RIGHT_TARGET = 3'd1;
  localparam logic [2:0] REG_TORQUE_GAIN  = 3'd2;
  localparam logic [2:0] REG_POWER_GAIN   = 3'd3;
  localparam logic [2:0] REG_TIMEOUT      = 3'd4;

  localparam logic [17:0] TORQUE_GAIN_RESET = 18'd199863;
  localparam logic [23:0] POWER_GAIN_RESET  = 24'd1987737;
  localparam logic [3:0]  TIMEOUT_RESET     = 4'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
  } mtd_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               last;
    logic [31:0]        ctrl_stamp;
    logic signed [15:0] target_rpm;
    logic signed [15:0] back_speed;
    logic signed [15:0] front_speed;
    logic [33:0]        back_trq;
    logic [33:0]        front_trq;
    logic signed [55:0] back_pwr;
    logic signed [55:0] front_pwr;
    logic [17:0]        battery_mv;
  } mtd_out_t;

  typedef struct packed {
    logic signed [15:0] left_target_rpm;
    logic signed [15:0] right_target_rpm;
    logic [17:0]        torque_gain;
    logic [23:0]        power_gain;
    logic [3:0]         reply_timeout;
  } mtd_cfg_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               last;
    logic [31:0]        ctrl_stamp;
    logic signed [15:0] target_rpm;
    logic signed [15:0] back_speed;
    logic signed [15:0] front_speed;
    logic [15:0]        back_current;
    logic [15:0]        front_current;
    logic [7:0]         volts;
    logic [7:0]         millivolts;
  } mtd_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL1,
    BK_MUL2,
    BK_SIGN
  } mtd_back_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mtd_queue.sv =====
// two-entry job queue between front and back
`default_nettype none
module mtd_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire mtd_pkg::mtd_job_t push_job,
  input  wire logic              pop,
  output logic                   full,
  output logic                   empty,
  output mtd_pkg::mtd_job_t      head
);
  import mtd_pkg::*;

  localparam logic [QPTR_W:0] DEPTH_COUNT = (QPTR_W + 1)'(QUEUE_DEPTH);

  mtd_job_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == DEPTH_COUNT);
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== hw/rtl/mtd_front.sv =====
// front end: frame gathering, classification and link bookkeeping
`default_nettype none
module mtd_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire mtd_pkg::mtd_in_t  item,
  input  wire mtd_pkg::mtd_cfg_t cfg,
  input  wire logic              q_full,
  output logic                   push,
  output mtd_pkg::mtd_job_t      push_job
);
  import mtd_pkg::*;

  logic [7:0] frame [FRAME_STORE];
  logic [4:0] byte_position, byte_position_next;
  logic [1:0] replies_pending, replies_pending_next;
  logic [3:0] empty_poll_count, empty_poll_count_next;
  logic       timeout_held, timeout_held_next;
  logic       store_en;
  logic       accept;
  logic       frame_ok;
  logic       is_left;
  logic [3:0] limit;
  logic [3:0] poll_inc;

  assign item_ready = !timeout_held && !q_full;
  assign accept     = item_valid && item_ready;
  assign frame_ok   = (frame[0] == SYNC_BYTE) && (frame[1] == HEAD_BYTE) &&
                      (frame[17] == SYNC_BYTE) && (item.rx_byte == FOOT_BYTE);
  assign is_left    = (frame[2] == SRC_LEFT);
  assign limit      = (cfg.reply_timeout == '0) ? 4'd1 : cfg.reply_timeout;
  assign poll_inc   = empty_poll_count + 4'd1;

  always_comb begin
    byte_position_next    = byte_position;
    replies_pending_next  = replies_pending;
    empty_poll_count_next = empty_poll_count;
    timeout_held_next     = timeout_held;
    store_en              = 1'b0;
    push                  = 1'b0;
    push_job              = '0;
    if (timeout_held) begin
      if (!q_full) begin
        push              = 1'b1;
        push_job.status   = ST_TIMEOUT;
        push_job.last     = 1'b1;
        timeout_held_next = 1'b0;
      end
    end else if (accept) begin
      case (item.kind)
        KIND_BYTE: begin
          empty_poll_count_next = '0;
          if (byte_position >= 5'(FRAME_STORE)) begin
            byte_position_next = '0;
            push               = 1'b1;
            push_job.last      = 1'b1;
            if (!frame_ok) begin
              push_job.status = ST_BAD;
            end else if (frame[2] != SRC_LEFT && frame[2] != SRC_RIGHT) begin
              push_job.status = ST_UNKNOWN;
            end else begin
              push_job.status        = is_left ? ST_LEFT : ST_RIGHT;
              push_job.ctrl_stamp    = {frame[13], frame[14], frame[15], frame[16]};
              push_job.target_rpm    = is_left ? cfg.left_target_rpm
                                               : cfg.right_target_rpm;
              push_job.back_current  = {frame[3], frame[4]};
              push_job.front_current = {frame[5], frame[6]};
              push_job.back_speed    = {frame[7], frame[8]};
              push_job.front_speed   = {frame[9], frame[10]};
              push_job.volts         = frame[11];
              push_job.millivolts    = frame[12];
              if (is_left) begin
                if (replies_pending != 2'd3) begin
                  replies_pending_next = replies_pending + 2'd1;
                end
              end else begin
                replies_pending_next = '0;
              end
            end
          end else begin
            store_en           = 1'b1;
            byte_position_next = byte_position + 5'd1;
          end
        end
        KIND_POLL: begin
          logic timed_out;
          timed_out = (replies_pending != '0) && (poll_inc >= limit);
          if (replies_pending != '0) begin
            empty_poll_count_next = timed_out ? 4'd0 : poll_inc;
            if (timed_out) begin
              replies_pending_next = '0;
            end
          end
          if (byte_position != '0) begin
            byte_position_next = '0;
            push               = 1'b1;
            push_job.status    = ST_PARTIAL;
            push_job.last      = !timed_out;
            timeout_held_next  = timed_out;
          end else if (timed_out) begin
            push            = 1'b1;
            push_job.status = ST_TIMEOUT;
            push_job.last   = 1'b1;
          end
        end
        KIND_SLOT: begin
          if (byte_position == '0 && replies_pending == '0) begin
            replies_pending_next = 2'd1;
            push                 = 1'b1;
            push_job.status      = ST_SEND;
            push_job.last        = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      frame[byte_position] <= item.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      replies_pending  <= '0;
      empty_poll_count <= '0;
      timeout_held     <= 1'b0;
    end else begin
      byte_position    <= byte_position_next;
      replies_pending  <= replies_pending_next;
      empty_poll_count <= empty_poll_count_next;
      timeout_held     <= timeout_held_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
      byte_position <= 5'(FRAME_STORE))
    else $error("byte position past frame");
  a_held_after_partial: assert property (@(posedge clk) disable iff (rst)
      $rose(timeout_held) |-> $past(push) && ($past(push_job.status) == ST_PARTIAL))
    else $error("timeout held without partial transfer");

endmodule
`default_nettype wire

// ===== hw/rtl/mtd_back.sv =====
// back end: torque, power and battery arithmetic and the result register
`default_nettype none
module mtd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire mtd_pkg::mtd_job_t q_head,
  input  wire mtd_pkg::mtd_cfg_t cfg,
  output logic                   pop,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output mtd_pkg::mtd_out_t      result
);
  import mtd_pkg::*;

  mtd_back_state_t state, state_next;
  mtd_job_t        job;
  logic            out_free;
  logic            load_simple;
  logic            load_data;
  logic            take_job;
  logic            head_is_data;
  logic [15:0]     back_mag, front_mag;
  logic [33:0]     back_trq, front_trq;
  logic [31:0]     back_prod, front_prod;
  logic [55:0]     back_pow, front_pow;
  logic [17:0]     battery;

  assign out_free     = !result_valid || result_ready;
  assign head_is_data = (q_head.status == ST_LEFT) || (q_head.status == ST_RIGHT);
  assign back_mag     = job.back_speed[15] ? 16'(-job.back_speed) : 16'(job.back_speed);
  assign front_mag    = job.front_speed[15] ? 16'(-job.front_speed) : 16'(job.front_speed);

  always_comb begin
    state_next  = state;
    pop         = 1'b0;
    load_simple = 1'b0;
    load_data   = 1'b0;
    take_job    = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          if (head_is_data) begin
            pop        = 1'b1;
            take_job   = 1'b1;
            state_next = BK_MUL1;
          end else if (out_free) begin
            pop         = 1'b1;
            load_simple = 1'b1;
          end
        end
      end
      BK_MUL1: state_next = BK_MUL2;
      BK_MUL2: state_next = BK_SIGN;
      BK_SIGN: begin
        if (out_free) begin
          load_data  = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take_job) begin
      job <= q_head;
    end
    if (state == BK_MUL1) begin
      back_trq   <= 34'(job.back_current) * 34'(cfg.torque_gain);
      front_trq  <= 34'(job.front_current) * 34'(cfg.torque_gain);
      back_prod  <= 32'(job.back_current) * 32'(back_mag);
      front_prod <= 32'(job.front_current) * 32'(front_mag);
      battery    <= 18'(job.volts) * 18'(MV_PER_VOLT) + 18'(job.millivolts);
    end
    if (state == BK_MUL2) begin
      back_pow  <= 56'(back_prod) * 56'(cfg.power_gain);
      front_pow <= 56'(front_prod) * 56'(cfg.power_gain);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_simple || load_data) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_simple) begin
      result.status      <= q_head.status;
      result.last        <= q_head.last;
      result.ctrl_stamp  <= '0;
      result.target_rpm  <= '0;
      result.back_speed  <= '0;
      result.front_speed <= '0;
      result.back_trq    <= '0;
      result.front_trq   <= '0;
      result.back_pwr    <= '0;
      result.front_pwr   <= '0;
      result.battery_mv  <= '0;
    end else if (load_data) begin
      result.status      <= job.status;
      result.last        <= job.last;
      result.ctrl_stamp  <= job.ctrl_stamp;
      result.target_rpm  <= job.target_rpm;
      result.back_speed  <= job.back_speed;
      result.front_speed <= job.front_speed;
      result.back_trq    <= back_trq;
      result.front_trq   <= front_trq;
      result.back_pwr    <= job.back_speed[15] ? signed'(-back_pow) : signed'(back_pow);
      result.front_pwr   <= job.front_speed[15] ? signed'(-front_pow) : signed'(front_pow);
      result.battery_mv  <= battery;
    end
  end

  a_simple_zero: assert property (@(posedge clk) disable iff (rst)
      result_valid && result.status != ST_LEFT && result.status != ST_RIGHT |->
      result.back_trq == '0 && result.back_pwr == '0 && result.battery_mv == '0)
    else $error("non-data result carries payload");
  a_chain_order: assert property (@(posedge clk) disable iff (rst)
      state == BK_MUL1 |=> state == BK_MUL2)
    else $error("multiplier chain skipped a step");

endmodule
`default_nettype wire

// ===== hw/rtl/motor_telemetry_deframer_unit.sv =====
// top level of the motor telemetry deframer
// Items come in on item_valid/item_ready with item.kind (received byte, empty
// poll, transmit slot) and item.rx_byte. Results leave on
// result_valid/result_ready as one status word per result; last marks the
// final result caused by an item. Registers are written through cfg_write,
// cfg_index and cfg_data; the user must write them only while the block is idle,
// which the block does not enforce. The front takes one item per cycle while
// its two-entry job queue has room and no timeout result is held; an empty
// poll that yields both a partial-drop and an unresponsive result holds off
// the next item until the held result is pushed into the queue. A result
// without payload passes through a queue entry and the result register. A
// good frame goes through the back's multiplier chain (current times torque
// gain and speed, then power gain, then sign) before the back takes a new job.
// When the receiver stalls, the result register holds, the queue fills and
// item_ready drops. Reset clears the frame position, reply tracking and all
// valid flags, and restores the register defaults; no clearing pass is run.
`default_nettype none
module motor_telemetry_deframer_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire mtd_pkg::mtd_in_t  item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output mtd_pkg::mtd_out_t      result,
  input  wire logic              cfg_write,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [23:0]       cfg_data
);
  import mtd_pkg::*;

  mtd_cfg_t cfg;
  logic     q_full;
  logic     q_empty;
  logic     push;
  logic     pop;
  mtd_job_t push_job;
  mtd_job_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_target_rpm  <= '0;
      cfg.right_target_rpm <= '0;
      cfg.torque_gain      <= TORQUE_GAIN_RESET;
      cfg.power_gain       <= POWER_GAIN_RESET;
      cfg.reply_timeout    <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LEFT_TARGET:  cfg.left_target_rpm  <= signed'(cfg_data[15:0]);
        REG_RIGHT_TARGET: cfg.right_target_rpm <= signed'(cfg_data[15:0]);
        REG_TORQUE_GAIN:  cfg.torque_gain      <= cfg_data[17:0];
        REG_POWER_GAIN:   cfg.power_gain       <= cfg_data;
        REG_TIMEOUT:      cfg.reply_timeout    <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  mtd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cfg        (cfg),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  mtd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  mtd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .cfg          (cfg),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire
